>>> sv/bna_pkg.sv
// ----------------------------------------------------------------------------
// bna_pkg
// Shared types and constants for the block number allocator.
// ----------------------------------------------------------------------------
package bna_pkg;

  localparam int NUM_CATEGORIES = 2;
  localparam int CAT_BITS       = 1;
  localparam int CACHE_SLOTS    = 100;
  localparam int SLOT_BITS      = $clog2(CACHE_SLOTS);
  localparam int CHUNK_ENTRIES  = 7;
  localparam int CHUNK_WORDS    = CHUNK_ENTRIES + 1;
  localparam int CNT_BITS       = $clog2(CHUNK_WORDS);
  localparam int BLOCK_BITS     = 12;
  localparam int FRESH_BITS     = BLOCK_BITS + 1;
  localparam int CACHE_AW       = CAT_BITS + SLOT_BITS;
  localparam int STORE_AW       = CAT_BITS + BLOCK_BITS;

  // Chunk word layout
  localparam int WORD_COUNT = 0;
  localparam int WORD_LINK  = 1;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_NO_BLOCKS    = 2'd1;
  localparam logic [1:0] ST_ZERO_RELEASE = 2'd2;

  typedef logic [BLOCK_BITS-1:0] blk_t;
  typedef logic [CHUNK_WORDS-1:0][BLOCK_BITS-1:0] chunk_t;

  typedef struct packed {
    logic                opcode;
    logic [CAT_BITS-1:0] category;
    blk_t                released_block;
  } req_t;

  typedef struct packed {
    blk_t       granted_block;
    logic [1:0] status;
  } rsp_t;

  typedef struct packed {
    logic                rd;   // take lowest filled slot
    logic                wr;   // fill lowest empty slot
    logic [CAT_BITS-1:0] cat;
  } cache_cmd_t;

  typedef struct packed {
    logic has_full;
    logic has_empty;
  } cache_sts_t;

endpackage

>>> sv/bna_cache.sv
// ----------------------------------------------------------------------------
// bna_cache
// Per-category slot cache: valid bits in flops, numbers in a synchronous RAM.
// ----------------------------------------------------------------------------
module bna_cache (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bna_pkg::cache_cmd_t cmd_i,
  input  bna_pkg::blk_t       wdata_i,
  output bna_pkg::cache_sts_t sts_o,
  output bna_pkg::blk_t       rdata_o
);
  import bna_pkg::*;

  logic [NUM_CATEGORIES-1:0][CACHE_SLOTS-1:0] valid_q, valid_d;
  blk_t                  mem [2**CACHE_AW];
  blk_t                  rdata_q;
  logic [SLOT_BITS-1:0]  full_idx, empty_idx;
  logic [CACHE_AW-1:0]   rd_addr, wr_addr;

  // Lowest filled and lowest empty slot of the selected category
  always_comb begin
    full_idx  = '0;
    empty_idx = '0;
    for (int j = CACHE_SLOTS - 1; j >= 0; j--) begin
      if (valid_q[cmd_i.cat][j]) begin
        full_idx = SLOT_BITS'(j);
      end else begin
        empty_idx = SLOT_BITS'(j);
      end
    end
  end

  assign sts_o.has_full  = |valid_q[cmd_i.cat];
  assign sts_o.has_empty = ~&valid_q[cmd_i.cat];
  assign rd_addr = {cmd_i.cat, full_idx};
  assign wr_addr = {cmd_i.cat, empty_idx};

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.rd) begin
      valid_d[cmd_i.cat][full_idx] = 1'b0;
    end
    if (cmd_i.wr) begin
      valid_d[cmd_i.cat][empty_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[wr_addr] <= wdata_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/bna_store.sv
// ----------------------------------------------------------------------------
// bna_store
// Chunk store: one whole chunk per word, single port, registered read.
// ----------------------------------------------------------------------------
module bna_store (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic                             we_i,
  input  logic [bna_pkg::STORE_AW-1:0]     addr_i,
  input  bna_pkg::chunk_t                  wdata_i,
  output bna_pkg::chunk_t                  rdata_o
);
  import bna_pkg::*;

  chunk_t mem [2**STORE_AW];
  chunk_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/block_number_allocator.sv
// ----------------------------------------------------------------------------
// block_number_allocator
// Hands out and takes back block numbers per category: slot cache first,
// then a chunked free list, then fresh blocks.
// ----------------------------------------------------------------------------
//  channel   signals                        direction  note
//  request   start, busy, req_i             in         taken when start & !busy
//  result    rsp_valid_o, rsp_o             out        one-cycle strobe, no stall
//  config    cfg_valid_i, cfg_ready_o,      in         first_fresh_block
//            cfg_data_i
//
//  A request passes through EXEC; a cache hit on allocate adds the S_CRD RAM
//  read state, a chunk load from the store adds S_LOAD (load, EXEC, load on the
//  rare load-then-pop path). Result strobes as the block returns to IDLE, when
//  busy is already low, so a new request is taken only once the last is done.
//  Reset clears the cache valid bits and all list heads at once; no sweep.
//  The receiver cannot stall; each request gives exactly one result.
// ----------------------------------------------------------------------------
module block_number_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  bna_pkg::req_t                  req_i,
  output logic                           rsp_valid_o,
  output bna_pkg::rsp_t                  rsp_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bna_pkg::BLOCK_BITS-1:0] cfg_data_i
);
  import bna_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;  // store read data arrives
  localparam logic [1:0] S_CRD  = 2'd3;  // cache read data arrives

  logic [1:0] state_q, state_d;
  req_t       req_q, req_d;
  logic       ret_q, ret_d;      // after a load, go back to EXEC
  rsp_t       rsp_q, rsp_d;
  logic       rsp_valid_q, rsp_valid_d;

  logic [NUM_CATEGORIES-1:0][FRESH_BITS-1:0] nfb_q, nfb_d;
  logic [NUM_CATEGORIES-1:0][BLOCK_BITS-1:0] head_q, head_d;
  logic [NUM_CATEGORIES-1:0][CNT_BITS-1:0]   cnt_q, cnt_d;
  chunk_t                                    buf_q [NUM_CATEGORIES];
  chunk_t                                    buf_d [NUM_CATEGORIES];

  cache_cmd_t          c_cmd;
  cache_sts_t          c_sts;
  blk_t                c_rdata;

  logic                st_en, st_we;
  logic [STORE_AW-1:0] st_addr;
  chunk_t              st_wdata, st_rdata;

  logic [CAT_BITS-1:0] cat;
  blk_t                head, link, w0;
  logic [CNT_BITS-1:0] cnt, cnt_m1, ld_cnt;

  assign cat    = req_q.category;
  assign head   = head_q[cat];
  assign cnt    = cnt_q[cat];
  assign cnt_m1 = cnt - CNT_BITS'(1);
  assign link   = buf_q[cat][WORD_LINK];

  // Count read from a chunk is held to 1..CHUNK_ENTRIES
  assign w0 = st_rdata[WORD_COUNT];
  always_comb begin
    priority if (w0 == '0) begin
      ld_cnt = CNT_BITS'(1);
    end else if (w0 > BLOCK_BITS'(CHUNK_ENTRIES)) begin
      ld_cnt = CNT_BITS'(CHUNK_ENTRIES);
    end else begin
      ld_cnt = w0[CNT_BITS-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    ret_d       = ret_q;
    rsp_d       = rsp_q;
    rsp_valid_d = 1'b0;
    nfb_d       = nfb_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    buf_d       = buf_q;
    c_cmd       = '{rd: 1'b0, wr: 1'b0, cat: cat};
    st_en       = 1'b0;
    st_we       = 1'b0;
    st_addr     = {cat, head};
    st_wdata    = buf_q[cat];
    st_wdata[WORD_COUNT] = BLOCK_BITS'(CHUNK_ENTRIES);

    unique case (state_q)
      S_IDLE: begin
        if (cfg_valid_i) begin
          for (int c = 0; c < NUM_CATEGORIES; c++) begin
            nfb_d[c] = (cfg_data_i == '0) ? FRESH_BITS'(1) : {1'b0, cfg_data_i};
          end
        end
        if (start) begin
          req_d   = req_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        rsp_d = '{granted_block: '0, status: ST_OK};
        if (req_q.opcode == OP_ALLOC) begin
          priority if (c_sts.has_full) begin
            c_cmd.rd = 1'b1;
            state_d  = S_CRD;
          end else if (head == '0) begin
            if (nfb_q[cat][BLOCK_BITS]) begin
              rsp_d.status = ST_NO_BLOCKS;
            end else begin
              rsp_d.granted_block = nfb_q[cat][BLOCK_BITS-1:0];
              nfb_d[cat]          = nfb_q[cat] + FRESH_BITS'(1);
            end
            rsp_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else if (cnt == '0) begin
            st_en   = 1'b1;
            ret_d   = 1'b1;
            state_d = S_LOAD;
          end else if (cnt_m1 == '0) begin
            // chunk used up: its own block goes out, follow the link
            rsp_d.granted_block = head;
            head_d[cat]         = link;
            cnt_d[cat]          = '0;
            if (link != '0) begin
              st_en   = 1'b1;
              st_addr = {cat, link};
              ret_d   = 1'b0;
              state_d = S_LOAD;
            end else begin
              rsp_valid_d = 1'b1;
              state_d     = S_IDLE;
            end
          end else begin
            rsp_d.granted_block = buf_q[cat][cnt];
            cnt_d[cat]          = cnt_m1;
            rsp_valid_d         = 1'b1;
            state_d             = S_IDLE;
          end
        end else begin
          priority if (req_q.released_block == '0) begin
            rsp_d.status = ST_ZERO_RELEASE;
            rsp_valid_d  = 1'b1;
            state_d      = S_IDLE;
          end else if (c_sts.has_empty) begin
            c_cmd.wr    = 1'b1;
            rsp_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else if (head != '0 && cnt == '0) begin
            st_en   = 1'b1;
            ret_d   = 1'b1;
            state_d = S_LOAD;
          end else begin
            if (cnt >= CNT_BITS'(CHUNK_ENTRIES) || cnt == '0) begin
              // full chunk goes to the store, new chunk links to old head
              if (cnt != '0) begin
                st_en = 1'b1;
                st_we = 1'b1;
              end
              buf_d[cat][WORD_LINK] = head;
              head_d[cat]           = req_q.released_block;
              cnt_d[cat]            = CNT_BITS'(1);
            end else begin
              buf_d[cat][cnt + CNT_BITS'(1)] = req_q.released_block;
              cnt_d[cat]                     = cnt + CNT_BITS'(1);
            end
            rsp_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
        end
      end

      S_LOAD: begin
        buf_d[cat] = st_rdata;
        cnt_d[cat] = ld_cnt;
        if (ret_q) begin
          state_d = S_EXEC;
        end else begin
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_CRD: begin
        rsp_d       = '{granted_block: c_rdata, status: ST_OK};
        rsp_valid_d = 1'b1;
        state_d     = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
      for (int c = 0; c < NUM_CATEGORIES; c++) begin
        nfb_q[c]  <= FRESH_BITS'(1);
        head_q[c] <= '0;
        cnt_q[c]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      rsp_valid_q <= rsp_valid_d;
      nfb_q       <= nfb_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
    buf_q <= buf_d;
  end

  bna_cache u_cache (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (c_cmd),
    .wdata_i (req_q.released_block),
    .sts_o   (c_sts),
    .rdata_o (c_rdata)
  );

  bna_store u_store (
    .clk_i   (clk_i),
    .en_i    (st_en),
    .we_i    (st_we),
    .addr_i  (st_addr),
    .wdata_i (st_wdata),
    .rdata_o (st_rdata)
  );

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

>>> sv/bna_checker.sv
// ----------------------------------------------------------------------------
// bna_port_props
// Port-level checks on the block number allocator.
// ----------------------------------------------------------------------------
module bna_port_props (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          rsp_valid_o,
  input bna_pkg::rsp_t rsp_o
);
  import bna_pkg::*;

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.status == ST_OK || rsp_o.status == ST_NO_BLOCKS ||
                     rsp_o.status == ST_ZERO_RELEASE))
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status != ST_OK) |-> rsp_o.granted_block == '0)
    else $error("error result carries a block");

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request taken without going busy");

  a_one_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !rsp_valid_o)
    else $error("back-to-back result strobes");

endmodule

bind block_number_allocator bna_port_props u_bna_port_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .rsp_valid_o (rsp_valid_o),
  .rsp_o       (rsp_o)
);

>>> test/bna_checker.sv
// ----------------------------------------------------------------------------
// bna_checker
// Watches the request, result and config channels of the allocator. It keeps
// its own copy of the cache, fresh counters and chunk lists, and checks each
// result against the oldest predicted one.
// ----------------------------------------------------------------------------
module bna_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  bna_pkg::req_t                  req_i,
  input  logic                           rsp_valid_i,
  input  bna_pkg::rsp_t                  rsp_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [bna_pkg::BLOCK_BITS-1:0] cfg_data_i,
  output int                             errors_o,
  output int                             pending_o
);
  import bna_pkg::*;

  localparam logic [FRESH_BITS-1:0] LAST_BLOCK = FRESH_BITS'((1 << BLOCK_BITS) - 1);

  blk_t                  slot_mdl  [NUM_CATEGORIES][CACHE_SLOTS];
  logic [FRESH_BITS-1:0] fresh_mdl [NUM_CATEGORIES];
  blk_t                  head_mdl  [NUM_CATEGORIES];
  int                    count_mdl [NUM_CATEGORIES];
  blk_t                  chunk_mdl [NUM_CATEGORIES][CHUNK_WORDS];
  blk_t                  store_mdl [int];
  rsp_t                  grants_q  [$];
  int                    errors;

  assign errors_o  = errors;
  assign pending_o = grants_q.size();

  function automatic int store_key(int c, blk_t b, int w);
    return ((c << BLOCK_BITS) | int'(b)) * CHUNK_WORDS + w;
  endfunction

  function automatic void chunk_load(int c, blk_t b);
    int n;
    for (int w = 0; w < CHUNK_WORDS; w++) begin
      chunk_mdl[c][w] = store_mdl.exists(store_key(c, b, w)) ?
                        store_mdl[store_key(c, b, w)] : '0;
    end
    n = int'(chunk_mdl[c][WORD_COUNT]);
    if (n < 1) n = 1;
    if (n > CHUNK_ENTRIES) n = CHUNK_ENTRIES;
    count_mdl[c] = n;
  endfunction

  function automatic void chunk_save(int c, blk_t b);
    chunk_mdl[c][WORD_COUNT] = blk_t'(count_mdl[c]);
    for (int w = 0; w < CHUNK_WORDS; w++) store_mdl[store_key(c, b, w)] = chunk_mdl[c][w];
  endfunction

  function automatic blk_t take_block(int c);
    blk_t b;
    blk_t h;
    for (int j = 0; j < CACHE_SLOTS; j++) begin
      if (slot_mdl[c][j] != '0) begin
        b = slot_mdl[c][j];
        slot_mdl[c][j] = '0;
        return b;
      end
    end
    h = head_mdl[c];
    if (h == '0) begin
      if (fresh_mdl[c] > LAST_BLOCK) return '0;
      b = blk_t'(fresh_mdl[c]);
      fresh_mdl[c] = fresh_mdl[c] + 1'b1;
      return b;
    end
    if (count_mdl[c] == 0) chunk_load(c, h);
    count_mdl[c]--;
    if (count_mdl[c] == 0) begin
      // chunk drained: the chunk block itself goes out last
      head_mdl[c] = chunk_mdl[c][WORD_LINK];
      if (head_mdl[c] != '0) chunk_load(c, head_mdl[c]);
      return h;
    end
    return chunk_mdl[c][count_mdl[c] + 1];
  endfunction

  function automatic void give_block(int c, blk_t b);
    blk_t h;
    for (int j = 0; j < CACHE_SLOTS; j++) begin
      if (slot_mdl[c][j] == '0) begin
        slot_mdl[c][j] = b;
        return;
      end
    end
    h = head_mdl[c];
    if (h != '0 && count_mdl[c] == 0) chunk_load(c, h);
    if (count_mdl[c] >= CHUNK_ENTRIES) begin
      count_mdl[c] = CHUNK_ENTRIES;
      chunk_save(c, h);
      count_mdl[c] = 0;
    end
    if (count_mdl[c] == 0) begin
      chunk_mdl[c][WORD_LINK] = h;
      head_mdl[c] = b;
    end else begin
      chunk_mdl[c][count_mdl[c] + 1] = b;
    end
    count_mdl[c]++;
  endfunction

  function automatic rsp_t predict_grant(req_t r);
    rsp_t o;
    int   c;
    c = int'(r.category) % NUM_CATEGORIES;
    o = '0;
    if (r.opcode == OP_ALLOC) begin
      o.granted_block = take_block(c);
      if (o.granted_block == '0) o.status = ST_NO_BLOCKS;
    end else if (r.released_block == '0) begin
      o.status = ST_ZERO_RELEASE;
    end else begin
      give_block(c, r.released_block);
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CATEGORIES; c++) begin
        for (int j = 0; j < CACHE_SLOTS; j++) slot_mdl[c][j] = '0;
        for (int w = 0; w < CHUNK_WORDS; w++) chunk_mdl[c][w] = '0;
        fresh_mdl[c] = FRESH_BITS'(1);
        head_mdl[c]  = '0;
        count_mdl[c] = 0;
      end
      store_mdl.delete();
      grants_q.delete();
      errors = 0;
    end else begin
      if (rsp_valid_i) begin
        if (grants_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", rsp_i);
        end else begin
          want = grants_q.pop_front();
          if (rsp_i.granted_block !== want.granted_block || rsp_i.status !== want.status) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: exp block %0d status %0d, got block %0d status %0d",
                       want.granted_block, want.status, rsp_i.granted_block, rsp_i.status);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        for (int c = 0; c < NUM_CATEGORIES; c++) begin
          fresh_mdl[c] = (cfg_data_i == '0) ? FRESH_BITS'(1) : FRESH_BITS'(cfg_data_i);
        end
      end
      if (start_i && !busy_i) grants_q.push_back(predict_grant(req_i));
    end
  end

endmodule

>>> test/tb_block_number_allocator.sv
// ----------------------------------------------------------------------------
// tb_block_number_allocator
// Drives allocate and release requests at the allocator through several
// first-fresh-block settings; bna_checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_block_number_allocator;
  import bna_pkg::*;

  localparam int WATCHDOG = 4000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  req_t                  req_i;
  logic                  rsp_valid_o;
  rsp_t                  rsp_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [BLOCK_BITS-1:0] cfg_data_i;
  int                    errors;
  int                    pending;
  int                    quiet_cycles;
  bit                    req_fire_n;  // handshake sampled mid-cycle
  bit                    cfg_fire_n;
  bit                    no_gaps;

  block_number_allocator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  bna_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req_i),
    .rsp_valid_i (rsp_valid_o),
    .rsp_i       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Outputs only move on the rising edge, so the value at the falling edge
  // is what the next rising edge sees.
  always @(negedge clk_i) begin
    req_fire_n = start && !busy;
    cfg_fire_n = cfg_valid_i && cfg_ready_o;
  end

  // Watchdog: cycles with no request, result or config accepted
  always @(posedge clk_i) begin
    if (req_fire_n || cfg_fire_n || rsp_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Issue one request; leaves start high so a back-to-back request follows
  // without a dip.
  task automatic send_request(logic op, logic cat, blk_t blk);
    start <= 1'b1;
    req_i <= '{opcode: op, category: cat, released_block: blk};
    do @(posedge clk_i); while (!req_fire_n);
  endtask

  task automatic maybe_gap();
    if (!no_gaps && $urandom_range(99) < 23) begin
      start <= 1'b0;
      req_i <= req_t'($urandom);
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  // Config writes only go in once every result is back and the block has
  // had time to settle.
  task automatic write_first_fresh(blk_t value);
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_fire_n);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic blk_t pick_block();
    int r;
    r = $urandom_range(99);
    if (r < 3) return '0;
    if (r < 6) return '1;
    return blk_t'($urandom_range(4095, 1));
  endfunction

  initial begin
    blk_t settings [5];
    int   burst;
    logic cat;
    settings     = '{12'd4095, 12'd1, 12'd2000, 12'd4090, 12'd3};
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    quiet_cycles = 0;
    no_gaps      = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset value, zero release, extreme blocks, both categories
    send_request(OP_ALLOC, 1'b0, '0);
    send_request(OP_ALLOC, 1'b1, '1);
    send_request(OP_RELEASE, 1'b0, '0);
    send_request(OP_RELEASE, 1'b1, '0);
    send_request(OP_RELEASE, 1'b0, 12'd4095);
    send_request(OP_RELEASE, 1'b1, 12'd1);
    send_request(OP_ALLOC, 1'b0, '0);
    send_request(OP_ALLOC, 1'b1, '0);
    send_request(OP_ALLOC, 1'b1, '0);
    // Fresh blocks run out after block 4095
    write_first_fresh(12'd4095);
    for (int i = 0; i < 4; i++) send_request(OP_ALLOC, 1'b0, '0);
    send_request(OP_ALLOC, 1'b1, '0);
    send_request(OP_ALLOC, 1'b1, '0);

    // Random: release bursts that can overflow the cache into chunks,
    // then allocate bursts that drain it back through the chunk list.
    foreach (settings[p]) begin
      write_first_fresh(settings[p]);
      no_gaps = (p == 2);
      cat     = 1'($urandom_range(1));
      burst   = $urandom_range(180, 110);
      for (int i = 0; i < burst; i++) begin
        maybe_gap();
        if ($urandom_range(99) < 8) begin
          send_request(OP_ALLOC, 1'($urandom_range(1)), pick_block());
        end else begin
          send_request(OP_RELEASE, ($urandom_range(99) < 85) ? cat : ~cat, pick_block());
        end
      end
      burst = $urandom_range(180, 110);
      for (int i = 0; i < burst; i++) begin
        maybe_gap();
        if ($urandom_range(99) < 10) begin
          send_request(OP_RELEASE, 1'($urandom_range(1)), pick_block());
        end else begin
          send_request(OP_ALLOC, ($urandom_range(99) < 85) ? cat : ~cat, pick_block());
        end
      end
    end

    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
sv/bna_pkg.sv
sv/bna_cache.sv
sv/bna_store.sv
sv/block_number_allocator.sv
sv/bna_checker.sv
test/bna_checker.sv
test/tb_block_number_allocator.sv
